/* sv/multilevel_bitmap_frame_allocator_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the multilevel bitmap frame allocator
// Clocked on clk and held off during arst_n. ASSERT_OFF removes them all.
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_BITMAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define MULTILEVEL_BITMAP_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// property checked at every clock edge outside reset
`define MBFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// implication checked at every clock edge outside reset
`define MBFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define MBFA_ASSERT(lbl, prop, msg)
`define MBFA_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* sv/mbfa_pkg.sv */
// ---------------------------------------------------------------------------
// mbfa_pkg
// Sizes, opcodes and level layout helpers of the bitmap frame allocator.
// ---------------------------------------------------------------------------
package mbfa_pkg;

	localparam int LEVELS      = 4;
	localparam int FRAMES      = 4096;
	localparam int FRAME_BYTES = 4096;
	localparam int WORD_BITS   = 64;

	localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);
	localparam int BIT_W       = $clog2(WORD_BITS);
	localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int SH_W        = $clog2(FRAME_SHIFT + LEVELS) + 1;

	localparam int ADR_W   = 32;
	localparam int LEN_W   = 32;
	localparam int MEMB_W  = 25;
	localparam int GRANT_W = 24;
	localparam int APB_W   = 32;
	localparam int PADDR_W = 3;

	localparam logic [MEMB_W-1:0] MEMB_RESET = 25'd16777216;
	localparam logic [0:0]        REG_MEMORY_BYTES = 1'b0;

	typedef enum logic [1:0] {
		OP_RESERVE = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_FREE    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// words of bitmap at a level (elaboration use)
	function automatic int words_of(input int lv);
		int bits;
		bits = FRAMES;
		for (int i = 0; i < lv; i++) begin
			bits = (bits + 1) >> 1;
		end
		return (bits + WORD_BITS - 1) / WORD_BITS;
	endfunction

	// first word of a level in the packed store (elaboration use)
	function automatic int off_of(input int lv);
		int s;
		s = 0;
		for (int i = 0; i < lv; i++) begin
			s = s + words_of(i);
		end
		return s;
	endfunction

	localparam int STORE_WORDS = off_of(LEVELS);
	localparam int ADDR_W      = $clog2(STORE_WORDS);
	localparam int CAP0        = words_of(0) * WORD_BITS;
	localparam int IDX_W       = $clog2(CAP0) + 2;
	localparam int WRD_W       = IDX_W - BIT_W;

	// bit capacity of a level
	function automatic logic [IDX_W-1:0] lvl_cap(input logic [LVL_W-1:0] lv);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (lv == LVL_W'(i)) r = IDX_W'(words_of(i) * WORD_BITS);
		end
		return r;
	endfunction

	// word count of a level
	function automatic logic [IDX_W-1:0] lvl_words(input logic [LVL_W-1:0] lv);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (lv == LVL_W'(i)) r = IDX_W'(words_of(i));
		end
		return r;
	endfunction

	// store address of a level's first word
	function automatic logic [ADDR_W-1:0] lvl_base(input logic [LVL_W-1:0] lv);
		logic [ADDR_W-1:0] r;
		r = '0;
		for (int i = 0; i < LEVELS; i++) begin
			if (lv == LVL_W'(i)) r = ADDR_W'(off_of(i));
		end
		return r;
	endfunction

endpackage

/* sv/multilevel_bitmap_frame_allocator_unit.sv */
// ---------------------------------------------------------------------------
// multilevel_bitmap_frame_allocator_unit
// Frame allocator over per-level occupancy bitmaps held in one word store,
// walked a word at a time by a single read-modify-write sequencer.
// ---------------------------------------------------------------------------
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+---------------------
//  command   | opcode, byte_address, byte_length              | start & !busy
//  result    | granted_address, failed                        | done, one cycle
//  config    | psel penable pwrite paddr pwdata prdata pready | APB, pready tied high
//
//  Each bitmap word takes a store read, then a modify and write.
//  Reserve: clamp, then per level a span step and each word touched.
//  Free: clamp, then per frame each level visited (parents climbed while clear).
//  Alloc: each word scanned (full and empty words in one step), a bit walk per
//  partly used word, then a reserve; the bit walk dominates.
//  Bitmaps read as free after reset through per-word valid flops; no sweep.
//  busy stays high until the result beat; the receiver cannot stall.
// ---------------------------------------------------------------------------
`include "multilevel_bitmap_frame_allocator_unit_assert.svh"

module multilevel_bitmap_frame_allocator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mbfa_pkg::PADDR_W-1:0]      paddr,
	input  logic [mbfa_pkg::APB_W-1:0]        pwdata,
	output logic [mbfa_pkg::APB_W-1:0]        prdata,
	output logic                              pready,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        opcode,
	input  logic [mbfa_pkg::ADR_W-1:0]        byte_address,
	input  logic [mbfa_pkg::LEN_W-1:0]        byte_length,
	output logic                              done,
	output logic [mbfa_pkg::GRANT_W-1:0]      granted_address,
	output logic                              failed
);

	localparam int W       = mbfa_pkg::WORD_BITS;
	localparam int BIT_W   = mbfa_pkg::BIT_W;
	localparam int IDX_W   = mbfa_pkg::IDX_W;
	localparam int WRD_W   = mbfa_pkg::WRD_W;
	localparam int LVL_W   = mbfa_pkg::LVL_W;
	localparam int ADDR_W  = mbfa_pkg::ADDR_W;
	localparam int MEMB_W  = mbfa_pkg::MEMB_W;
	localparam int ADR_W   = mbfa_pkg::ADR_W;
	localparam int SH_W    = mbfa_pkg::SH_W;
	localparam int FS      = mbfa_pkg::FRAME_SHIFT;
	localparam logic [LVL_W-1:0] LV_LAST  = LVL_W'(mbfa_pkg::LEVELS - 1);
	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(W - 1);
	localparam logic [W-1:0]     FULL     = {W{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE, S_CLAMP, S_RES_LVL, S_RES_RD, S_RES_WR, S_FREE_SET, S_FREE_RD,
		S_FREE_WR, S_ALC_PICK, S_ALC_LVL, S_ALC_RD, S_ALC_WORD, S_ALC_BIT, S_DONE
	} state_t;

	state_t                      state_q;
	mbfa_pkg::op_t               op_q;
	logic [ADR_W-1:0]            addr_q;
	logic [mbfa_pkg::LEN_W-1:0]  len_q;
	logic [MEMB_W-1:0]           ca_q, cl_q, memb_q;
	logic [LVL_W-1:0]            lv_q;
	logic [IDX_W-1:0]            first_q, end_q, fidx_q, fend_q, bidx_q, need_q, run_q;
	logic [WRD_W-1:0]            wrd_q;
	logic [BIT_W-1:0]            bpos_q;
	logic                        inr_q, done_q, failed_q;
	logic [mbfa_pkg::GRANT_W-1:0] grant_q;

	// bitmap store
	logic [W-1:0]                mem [mbfa_pkg::STORE_WORDS];
	logic [mbfa_pkg::STORE_WORDS-1:0] vld_q;
	logic [W-1:0]                rdata_q;
	logic                        rvld_q;
	logic                        mem_re, mem_we;
	logic [ADDR_W-1:0]           mem_addr;
	logic [W-1:0]                mem_wd;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == mbfa_pkg::REG_MEMORY_BYTES) ?
		{{(mbfa_pkg::APB_W - MEMB_W){1'b0}}, memb_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memb_q <= mbfa_pkg::MEMB_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[2:2] == mbfa_pkg::REG_MEMORY_BYTES) begin
			memb_q <= pwdata[MEMB_W-1:0];
		end
	end

	// ------------------------------------------------------- shared datapath
	logic [SH_W-1:0]   sh;
	logic [31:0]       blk_m;
	logic [IDX_W-1:0]  cur_cap, cur_words;
	logic [W-1:0]      cur_word;

	assign sh        = SH_W'(FS) + SH_W'(lv_q);
	assign blk_m     = (32'd1 << sh) - 32'd1;
	assign cur_cap   = mbfa_pkg::lvl_cap(lv_q);
	assign cur_words = mbfa_pkg::lvl_words(lv_q);
	assign cur_word  = rvld_q ? rdata_q : '0;

	// clamp to memory size
	logic [32:0]       sum33;
	logic [MEMB_W-1:0] clamped;
	assign sum33   = {1'b0, addr_q} + {1'b0, len_q};
	assign clamped = (sum33 > 33'(memb_q)) ? (memb_q - addr_q[MEMB_W-1:0])
		: len_q[MEMB_W-1:0];

	// reserve: block span on the current level
	logic [MEMB_W-1:0] rrem, rfirst;
	logic [25:0]       rlen;
	logic [26:0]       rcnt;
	logic [27:0]       rsum;
	logic              res_skip;
	logic [IDX_W-1:0]  res_end, endm1;
	logic [WRD_W-1:0]  last_wrd, first_wrd;
	logic [BIT_W-1:0]  lo, hi;
	logic [W-1:0]      res_mask;

	assign rrem     = ca_q & blk_m[MEMB_W-1:0];
	assign rlen     = {1'b0, cl_q} + {1'b0, rrem};
	assign rcnt     = ({1'b0, rlen} + {2'b0, blk_m[MEMB_W-1:0]}) >> sh;
	assign rfirst   = ca_q >> sh;
	assign rsum     = {3'b0, rfirst} + {1'b0, rcnt};
	assign res_skip = (rfirst >= MEMB_W'(cur_cap)) || (rcnt == '0);
	assign res_end  = (rsum > 28'(cur_cap)) ? cur_cap : rsum[IDX_W-1:0];

	// word mask between first and end bits
	assign endm1     = end_q - IDX_W'(1);
	assign last_wrd  = WRD_W'(endm1 >> BIT_W);
	assign first_wrd = WRD_W'(first_q >> BIT_W);
	assign lo        = (wrd_q == first_wrd) ? first_q[BIT_W-1:0] : '0;
	assign hi        = (wrd_q == last_wrd) ? endm1[BIT_W-1:0] : BIT_LAST;
	assign res_mask  = (FULL << lo) & (FULL >> (BIT_LAST - hi));

	// free: frame span and parent climb
	logic [MEMB_W-1:0] fidx0;
	logic [26:0]       fn;
	logic [W-1:0]      free_word;
	logic              pair_clear;

	assign fidx0     = ca_q >> FS;
	assign fn        = ({2'b0, cl_q} + 27'(ca_q[FS-1:0]) + 27'(mbfa_pkg::FRAME_BYTES - 1)) >> FS;
	assign free_word = (inr_q ? cur_word : '0) & ~(W'(1) << bidx_q[BIT_W-1:0]);
	assign pair_clear = !free_word[{bidx_q[BIT_W-1:1], 1'b0}]
		&& !free_word[{bidx_q[BIT_W-1:1], 1'b1}];

	// alloc: level pick, blocks needed, run search
	logic [LVL_W-1:0] pick_lv;
	logic [32:0]      need_raw;
	logic             need_bad;
	logic [IDX_W-1:0] wbase, run_nx, alc_start;
	logic             alc_found, alc_adv, bit_go, wrd_end;
	logic [ADR_W-1:0] grant_addr;

	always_comb begin
		pick_lv = LV_LAST;
		for (int i = mbfa_pkg::LEVELS - 1; i >= 0; i--) begin
			if ({1'b0, len_q} <= (33'(mbfa_pkg::FRAME_BYTES) << i)) pick_lv = LVL_W'(i);
		end
	end

	assign need_raw   = ({1'b0, len_q} + {1'b0, blk_m}) >> sh;
	assign need_bad   = (need_raw == '0) || (need_raw > 33'(cur_cap));
	assign wbase      = {wrd_q, {BIT_W{1'b0}}};
	assign wrd_end    = (IDX_W'(wrd_q) + IDX_W'(1)) == cur_words;
	assign grant_addr = ADR_W'(alc_start) << sh;

	always_comb begin
		alc_found = 1'b0;
		alc_adv   = 1'b0;
		bit_go    = 1'b0;
		alc_start = '0;
		run_nx    = run_q;
		if (state_q == S_ALC_WORD) begin
			if (cur_word == FULL) begin
				run_nx  = '0;
				alc_adv = 1'b1;
			end else if (cur_word == '0) begin
				if (run_q + IDX_W'(W) >= need_q) begin
					alc_found = 1'b1;
					alc_start = wbase - run_q;
				end else begin
					run_nx  = run_q + IDX_W'(W);
					alc_adv = 1'b1;
				end
			end else begin
				bit_go = 1'b1;
			end
		end else if (state_q == S_ALC_BIT) begin
			if (cur_word[bpos_q]) begin
				run_nx = '0;
			end else if (run_q + IDX_W'(1) == need_q) begin
				alc_found = 1'b1;
				alc_start = wbase + IDX_W'(bpos_q) + IDX_W'(1) - need_q;
			end else begin
				run_nx = run_q + IDX_W'(1);
			end
			alc_adv = !alc_found && (bpos_q == BIT_LAST);
		end
	end

	// store port control
	logic [WRD_W-1:0] word_sel;
	assign word_sel = (state_q == S_FREE_RD || state_q == S_FREE_WR)
		? WRD_W'(bidx_q >> BIT_W) : wrd_q;
	assign mem_addr = mbfa_pkg::lvl_base(lv_q) + ADDR_W'(word_sel);
	assign mem_re   = (state_q == S_RES_RD) || (state_q == S_FREE_RD) || (state_q == S_ALC_RD);
	assign mem_we   = (state_q == S_RES_WR) || (state_q == S_FREE_WR && inr_q);
	assign mem_wd   = (state_q == S_RES_WR) ? (cur_word | res_mask) : free_word;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (mem_we) vld_q[mem_addr] <= 1'b1;
			if (mem_re) rvld_q <= vld_q[mem_addr];
		end
	end

	// ------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			failed_q <= 1'b0;
			grant_q  <= '0;
		end else begin
			done_q <= (state_q == S_DONE);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q     <= mbfa_pkg::op_t'(opcode);
						addr_q   <= byte_address;
						len_q    <= byte_length;
						grant_q  <= '0;
						failed_q <= 1'b0;
						if (opcode inside {mbfa_pkg::OP_RESERVE, mbfa_pkg::OP_FREE}) begin
							state_q <= S_CLAMP;
						end else if (opcode == mbfa_pkg::OP_ALLOC) begin
							state_q <= S_ALC_PICK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_CLAMP: begin
					if (addr_q > ADR_W'(memb_q)) begin
						state_q <= S_DONE;
					end else begin
						ca_q    <= addr_q[MEMB_W-1:0];
						cl_q    <= clamped;
						lv_q    <= '0;
						state_q <= (op_q == mbfa_pkg::OP_FREE) ? S_FREE_SET : S_RES_LVL;
					end
				end
				S_RES_LVL: begin
					if (res_skip) begin
						if (lv_q == LV_LAST) state_q <= S_DONE;
						else lv_q <= lv_q + LVL_W'(1);
					end else begin
						first_q <= rfirst[IDX_W-1:0];
						end_q   <= res_end;
						wrd_q   <= WRD_W'(rfirst >> BIT_W);
						state_q <= S_RES_RD;
					end
				end
				S_RES_RD: begin
					state_q <= S_RES_WR;
				end
				S_RES_WR: begin
					if (wrd_q == last_wrd) begin
						if (lv_q == LV_LAST) begin
							state_q <= S_DONE;
						end else begin
							lv_q    <= lv_q + LVL_W'(1);
							state_q <= S_RES_LVL;
						end
					end else begin
						wrd_q   <= wrd_q + WRD_W'(1);
						state_q <= S_RES_RD;
					end
				end
				S_FREE_SET: begin
					if (fn == '0) begin
						state_q <= S_DONE;
					end else begin
						fidx_q  <= fidx0[IDX_W-1:0];
						bidx_q  <= fidx0[IDX_W-1:0];
						fend_q  <= IDX_W'(fidx0) + IDX_W'(fn);
						lv_q    <= '0;
						state_q <= S_FREE_RD;
					end
				end
				S_FREE_RD: begin
					inr_q   <= bidx_q < cur_cap;
					state_q <= S_FREE_WR;
				end
				S_FREE_WR: begin
					if (lv_q != LV_LAST && pair_clear) begin
						lv_q    <= lv_q + LVL_W'(1);
						bidx_q  <= bidx_q >> 1;
						state_q <= S_FREE_RD;
					end else if (fidx_q + IDX_W'(1) == fend_q) begin
						state_q <= S_DONE;
					end else begin
						fidx_q  <= fidx_q + IDX_W'(1);
						bidx_q  <= fidx_q + IDX_W'(1);
						lv_q    <= '0;
						state_q <= S_FREE_RD;
					end
				end
				S_ALC_PICK: begin
					lv_q    <= pick_lv;
					state_q <= S_ALC_LVL;
				end
				S_ALC_LVL: begin
					if (need_bad) begin
						if (lv_q == '0) begin
							failed_q <= 1'b1;
							state_q  <= S_DONE;
						end else begin
							lv_q <= lv_q - LVL_W'(1);
						end
					end else begin
						need_q  <= need_raw[IDX_W-1:0];
						run_q   <= '0;
						wrd_q   <= '0;
						state_q <= S_ALC_RD;
					end
				end
				S_ALC_RD: begin
					state_q <= S_ALC_WORD;
				end
				S_ALC_WORD, S_ALC_BIT: begin
					run_q <= run_nx;
					if (alc_found) begin
						// claim the run through the reserve path
						addr_q  <= grant_addr;
						grant_q <= grant_addr[mbfa_pkg::GRANT_W-1:0];
						state_q <= S_CLAMP;
					end else if (alc_adv) begin
						if (!wrd_end) begin
							wrd_q   <= wrd_q + WRD_W'(1);
							state_q <= S_ALC_RD;
						end else if (lv_q == '0) begin
							failed_q <= 1'b1;
							state_q  <= S_DONE;
						end else begin
							lv_q    <= lv_q - LVL_W'(1);
							state_q <= S_ALC_LVL;
						end
					end else if (bit_go) begin
						bpos_q  <= '0;
						state_q <= S_ALC_BIT;
					end else begin
						bpos_q <= bpos_q + BIT_W'(1);
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign granted_address = grant_q;
	assign failed          = failed_q;

	// ------------------------------------------------------------ assertions
	`MBFA_ASSERT(a_done_after_cmd, done |-> $past(busy), "result beat without a command")
	`MBFA_ASSERT_IMP(a_fail_no_addr, failed, granted_address == '0, "failed grant has address")
	`MBFA_ASSERT_IMP(a_write_busy, mem_we, busy, "bitmap write while idle")
	`MBFA_ASSERT(a_start_busy, (start && !busy) |=> busy, "command taken but not busy")

endmodule
